### rtl/ffra_pkg.sv
`default_nettype none
package ffra_pkg;

  // result status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_ZERO     = 3'd1;
  localparam logic [2:0] ST_NOFIT    = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;

  // item operation codes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [15:0] POOL_RESET = 16'd1000;

  // controller -> datapath commands
  typedef struct packed {
    logic load;      // capture item fields, clear scan index
    logic scan_inc;  // advance scan index
    logic split;     // split segment at scan index (shift up sweep start)
    logic shift_up;  // one step of upward shift
    logic mark_use;  // mark scan entry allocated
    logic merge_nxt; // merge scan entry with its successor
    logic merge_prv; // merge scan entry into predecessor
    logic mark_free; // mark scan entry free
    logic shift_dn;  // one step of downward shift
  } ffra_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic scan_end;   // scan index at segment count
    logic alloc_hit;  // scan entry free and long enough
    logic exact;      // scan entry length equals request
    logic free_hit;   // scan entry allocated and starts at address
    logic full;       // table has no spare entry
    logic up_done;    // upward shift reached the split point
    logic dn_done;    // downward shift reached the top
    logic nxt_free;   // successor exists and is free
    logic prv_free;   // predecessor exists and is free
    logic zero_req;   // request size is zero
    logic is_free_op; // item is a free
  } ffra_sts_t;

endpackage
`default_nettype wire

### rtl/ffra_datapath.sv
`default_nettype none
module ffra_datapath #(
  parameter int MAX_SEGMENTS = 16,
  parameter int ADDR_BITS    = 16
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    cfg_we,
  input  wire [15:0]             cfg_data,
  input  ffra_pkg::ffra_cmd_t    cmd,
  input  wire                    in_operation,
  input  wire [15:0]             in_request_size,
  input  wire [15:0]             in_release_address,
  output ffra_pkg::ffra_sts_t    sts,
  output logic [15:0]            addr_out
);
  import ffra_pkg::*;

  localparam int IW = $clog2(MAX_SEGMENTS);
  localparam int CW = $clog2(MAX_SEGMENTS + 1);

  logic [ADDR_BITS-1:0] seg_start_r [MAX_SEGMENTS];
  logic [ADDR_BITS-1:0] seg_len_r   [MAX_SEGMENTS];
  logic [MAX_SEGMENTS-1:0] seg_use_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] idx_r;   // scan index
  logic [CW-1:0] sh_r;    // shift pointer
  logic op_r;
  logic [ADDR_BITS-1:0] size_r;
  logic [ADDR_BITS-1:0] rel_r;
  logic [15:0] rel_echo_r;

  logic [IW-1:0] ix, ixn, ixp, shi, shim;
  assign ix   = idx_r[IW-1:0];
  assign ixn  = IW'(idx_r + CW'(1));
  assign ixp  = IW'(idx_r - CW'(1));
  assign shi  = sh_r[IW-1:0];
  assign shim = IW'(sh_r - CW'(1));

  logic [ADDR_BITS-1:0] cur_start, cur_len;
  logic cur_use;
  assign cur_start = seg_start_r[ix];
  assign cur_len   = seg_len_r[ix];
  assign cur_use   = seg_use_r[ix];

  // status to controller
  always_comb begin
    sts.scan_end   = (idx_r >= count_r);
    sts.alloc_hit  = !cur_use && (cur_len >= size_r);
    sts.exact      = (cur_len == size_r);
    sts.free_hit   = cur_use && (cur_start == rel_r);
    sts.full       = (count_r >= CW'(MAX_SEGMENTS));
    sts.up_done    = (sh_r <= idx_r + CW'(1));
    sts.dn_done    = (sh_r >= count_r);
    sts.nxt_free   = (idx_r + CW'(1) < count_r) && !seg_use_r[ixn];
    sts.prv_free   = (idx_r != '0) && !seg_use_r[ixp];
    sts.zero_req   = (size_r == '0);
    sts.is_free_op = (op_r == OP_FREE);
  end

  // result address: entry start on alloc, echo on free
  always_comb begin
    addr_out = (op_r == OP_FREE) ? rel_echo_r : 16'(cur_start);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= CW'(1);
      seg_use_r <= '0;
      idx_r     <= '0;
      sh_r      <= '0;
    end else if (cfg_we) begin
      count_r   <= CW'(1);
      seg_use_r <= '0;
    end else begin
      if (cmd.load) idx_r <= '0;
      if (cmd.scan_inc) idx_r <= idx_r + CW'(1);
      if (cmd.split) begin
        sh_r    <= count_r;
        count_r <= count_r + CW'(1);
      end
      if (cmd.shift_up) begin
        seg_use_r[shi] <= seg_use_r[shim];
        sh_r <= sh_r - CW'(1);
      end
      if (cmd.mark_use) seg_use_r[ix] <= 1'b1;
      // split remainder is free
      if (cmd.mark_use && !sts.exact) seg_use_r[ixn] <= 1'b0;
      if (cmd.mark_free) seg_use_r[ix] <= 1'b0;
      if (cmd.merge_nxt) begin
        seg_use_r[ix] <= 1'b0;
        sh_r    <= idx_r + CW'(1);
        count_r <= count_r - CW'(1);
      end
      if (cmd.merge_prv) begin
        sh_r    <= idx_r;
        count_r <= count_r - CW'(1);
      end
      if (cmd.shift_dn) begin
        seg_use_r[shi] <= seg_use_r[IW'(sh_r + CW'(1))];
        sh_r <= sh_r + CW'(1);
      end
    end
  end

  // segment table payload
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      seg_start_r[0] <= '0;
      seg_len_r[0]   <= ADDR_BITS'(rst_n ? cfg_data : POOL_RESET);
    end else begin
      if (cmd.load) begin
        op_r       <= in_operation;
        size_r     <= ADDR_BITS'(in_request_size);
        rel_r      <= ADDR_BITS'(in_release_address);
        rel_echo_r <= in_release_address;
      end
      if (cmd.shift_up) begin
        seg_start_r[shi] <= seg_start_r[shim];
        seg_len_r[shi]   <= seg_len_r[shim];
      end
      // split completes when the hole sits just above the scan entry
      if (cmd.mark_use && !sts.exact) begin
        seg_start_r[ixn] <= cur_start + size_r;
        seg_len_r[ixn]   <= cur_len - size_r;
        seg_len_r[ix]    <= size_r;
      end
      if (cmd.merge_nxt) seg_len_r[ix] <= cur_len + seg_len_r[ixn];
      if (cmd.merge_prv) seg_len_r[ixp] <= seg_len_r[ixp] + cur_len;
      if (cmd.shift_dn) begin
        seg_start_r[shi] <= seg_start_r[IW'(sh_r + CW'(1))];
        seg_len_r[shi]   <= seg_len_r[IW'(sh_r + CW'(1))];
      end
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r >= CW'(1) && count_r <= CW'(MAX_SEGMENTS))
    else $error("segment count out of range");
  a_cfg_reset: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> count_r == CW'(1) && seg_use_r == '0)
    else $error("config write did not rebuild table");
  a_split_grows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.split && !cfg_we |=> count_r == $past(count_r) + CW'(1))
    else $error("split did not grow table");
`endif
endmodule
`default_nettype wire

### rtl/ffra_ctrl.sv
`default_nettype none
module ffra_ctrl (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  start,
  output logic                 busy,
  input  ffra_pkg::ffra_sts_t  sts,
  output ffra_pkg::ffra_cmd_t  cmd,
  output logic                 done,
  output logic [2:0]           status
);
  import ffra_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_ASCAN, S_SHUP, S_AFIN,
    S_FSCAN, S_FNXT, S_SHDN1, S_FPRV, S_SHDN2, S_FDONE
  } state_t;

  state_t state_r, state_nxt;
  logic done_nxt;
  logic [2:0] status_nxt;

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    done_nxt   = 1'b0;
    status_nxt = status;
    unique case (state_r)
      S_IDLE: if (start) begin
        cmd.load  = 1'b1;
        state_nxt = S_DISPATCH;
      end
      S_DISPATCH: begin
        if (sts.is_free_op) state_nxt = S_FSCAN;
        else if (sts.zero_req) begin
          done_nxt = 1'b1; status_nxt = ST_ZERO; state_nxt = S_IDLE;
        end else state_nxt = S_ASCAN;
      end
      // first-fit search
      S_ASCAN: begin
        if (sts.scan_end) begin
          done_nxt = 1'b1; status_nxt = ST_NOFIT; state_nxt = S_IDLE;
        end else if (sts.alloc_hit) begin
          if (sts.exact) begin
            cmd.mark_use = 1'b1; state_nxt = S_AFIN;
          end else if (sts.full) begin
            done_nxt = 1'b1; status_nxt = ST_FULL; state_nxt = S_IDLE;
          end else begin
            cmd.split = 1'b1; state_nxt = S_SHUP;
          end
        end else cmd.scan_inc = 1'b1;
      end
      S_SHUP: begin
        if (sts.up_done) begin
          cmd.mark_use = 1'b1; state_nxt = S_AFIN;
        end else cmd.shift_up = 1'b1;
      end
      S_AFIN: begin
        done_nxt = 1'b1; status_nxt = ST_OK; state_nxt = S_IDLE;
      end
      // address match search
      S_FSCAN: begin
        if (sts.scan_end) begin
          done_nxt = 1'b1; status_nxt = ST_NOTFOUND; state_nxt = S_IDLE;
        end else if (sts.free_hit) begin
          if (sts.nxt_free) begin
            cmd.merge_nxt = 1'b1; state_nxt = S_SHDN1;
          end else begin
            cmd.mark_free = 1'b1; state_nxt = S_FNXT;
          end
        end else cmd.scan_inc = 1'b1;
      end
      S_FNXT, S_SHDN1: begin
        if (state_r == S_SHDN1 && !sts.dn_done) cmd.shift_dn = 1'b1;
        else state_nxt = S_FPRV;
      end
      S_FPRV: begin
        if (sts.prv_free) begin
          cmd.merge_prv = 1'b1; state_nxt = S_SHDN2;
        end else state_nxt = S_FDONE;
      end
      S_SHDN2: begin
        if (sts.dn_done) state_nxt = S_FDONE;
        else cmd.shift_dn = 1'b1;
      end
      S_FDONE: begin
        done_nxt = 1'b1; status_nxt = ST_OK; state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state and registered result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done    <= 1'b0;
      status  <= ST_OK;
    end else begin
      state_r <= state_nxt;
      done    <= done_nxt;
      status  <= status_nxt;
    end
  end

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> state_r == S_IDLE)
    else $error("result strobe outside idle");
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> !done)
    else $error("result strobe longer than one cycle");
  a_load_start: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> start && !busy)
    else $error("item loaded without start");
`endif
endmodule
`default_nettype wire

### rtl/first_fit_region_allocator_core.sv
// First-fit region allocator. Pulse start with an item while busy is low;
// exactly one result follows on out_valid for a single cycle, which the
// receiver cannot stall. The table is kept in registers and walked one
// entry per cycle by the search, then shifted one entry per cycle on a
// split or a merge. Write cfg_pool_size only while busy is low and no
// result is pending; it rebuilds the table to one free segment, seen from
// the cycle after the write.
`default_nettype none
module first_fit_region_allocator_core #(
  parameter int MAX_SEGMENTS = 16,
  parameter int ADDR_BITS    = 16
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         start,
  output logic        busy,
  input  wire         in_operation,
  input  wire  [15:0] in_request_size,
  input  wire  [15:0] in_release_address,
  output logic        out_valid,
  output logic [15:0] out_region_address,
  output logic [2:0]  out_status,
  input  wire         cfg_we,
  input  wire  [15:0] cfg_pool_size
);
  import ffra_pkg::*;

  ffra_cmd_t cmd;
  ffra_sts_t sts;
  logic [15:0] addr;
  logic [2:0] st;

  ffra_ctrl u_ctrl (
    .clk, .rst_n, .start, .busy, .sts, .cmd,
    .done(out_valid), .status(st)
  );

  ffra_datapath #(.MAX_SEGMENTS(MAX_SEGMENTS), .ADDR_BITS(ADDR_BITS)) u_dp (
    .clk, .rst_n, .cfg_we, .cfg_data(cfg_pool_size), .cmd,
    .in_operation, .in_request_size, .in_release_address,
    .sts, .addr_out(addr)
  );

  // address is zero on failed allocate
  assign out_status = st;
  assign out_region_address = (st == ST_OK || sts.is_free_op) ? addr : 16'd0;

endmodule
`default_nettype wire

### test/testbench.sv
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ffra_pkg::*;

  localparam int SEG_MAX = 16;
  localparam int IDLE_LIMIT = 4000;

  // allocator table predictor plus queue of pending results
  class alloc_scoreboard;
    logic [15:0] seg_base[SEG_MAX];
    logic [15:0] seg_len[SEG_MAX];
    bit          seg_used[SEG_MAX];
    int          seg_num;
    logic [15:0] pend_addr[$];
    logic [2:0]  pend_status[$];
    int          errors;

    function void rebuild(logic [15:0] pool);
      for (int k = 0; k < SEG_MAX; k++) begin
        seg_base[k] = '0;
        seg_len[k] = '0;
        seg_used[k] = 0;
      end
      seg_len[0] = pool;
      seg_num = 1;
    endfunction

    function void drop_entry(int idx);
      for (int k = idx; k + 1 < seg_num; k++) begin
        seg_base[k] = seg_base[k+1];
        seg_len[k] = seg_len[k+1];
        seg_used[k] = seg_used[k+1];
      end
      seg_num--;
    endfunction

    // apply one accepted item to the table and queue its result
    function void note_item(logic op, logic [15:0] req, logic [15:0] rel);
      logic [15:0] addr;
      logic [2:0]  st;
      int i;
      addr = '0;
      if (op == OP_ALLOC) begin
        if (req == 0) st = ST_ZERO;
        else begin
          for (i = 0; i < seg_num; i++)
            if (!seg_used[i] && seg_len[i] >= req) break;
          if (i >= seg_num) st = ST_NOFIT;
          else if (seg_len[i] == req) begin
            seg_used[i] = 1;
            addr = seg_base[i];
            st = ST_OK;
          end else if (seg_num >= SEG_MAX) st = ST_FULL;
          else begin
            for (int k = seg_num; k > i + 1; k--) begin
              seg_base[k] = seg_base[k-1];
              seg_len[k] = seg_len[k-1];
              seg_used[k] = seg_used[k-1];
            end
            seg_num++;
            seg_base[i+1] = seg_base[i] + req;
            seg_len[i+1] = seg_len[i] - req;
            seg_used[i+1] = 0;
            seg_len[i] = req;
            seg_used[i] = 1;
            addr = seg_base[i];
            st = ST_OK;
          end
        end
      end else begin
        addr = rel;
        for (i = 0; i < seg_num; i++)
          if (seg_used[i] && seg_base[i] == rel) break;
        if (i >= seg_num) st = ST_NOTFOUND;
        else begin
          st = ST_OK;
          seg_used[i] = 0;
          if (i + 1 < seg_num && !seg_used[i+1]) begin
            seg_len[i] = seg_len[i] + seg_len[i+1];
            drop_entry(i + 1);
          end
          if (i > 0 && !seg_used[i-1]) begin
            seg_len[i-1] = seg_len[i-1] + seg_len[i];
            drop_entry(i);
          end
        end
      end
      pend_addr.push_back(addr);
      pend_status.push_back(st);
    endfunction

    function void check_result(logic [15:0] addr, logic [2:0] st);
      logic [15:0] ea;
      logic [2:0]  es;
      if (pend_addr.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result addr=%0d status=%0d", addr, st);
        return;
      end
      ea = pend_addr.pop_front();
      es = pend_status.pop_front();
      if (ea !== addr || es !== st) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected addr=%0d status=%0d, got addr=%0d status=%0d",
                   ea, es, addr, st);
      end
    endfunction

    // base address of some allocated segment, or a random value if none
    function logic [15:0] live_base();
      int cnt;
      int pick;
      cnt = 0;
      for (int k = 0; k < seg_num; k++) if (seg_used[k]) cnt++;
      if (cnt == 0) return 16'($urandom);
      pick = $urandom_range(cnt - 1);
      for (int k = 0; k < seg_num; k++)
        if (seg_used[k]) begin
          if (pick == 0) return seg_base[k];
          pick--;
        end
      return '0;
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  wire         busy;
  logic        in_operation;
  logic [15:0] in_request_size;
  logic [15:0] in_release_address;
  wire         out_valid;
  wire  [15:0] out_region_address;
  wire  [2:0]  out_status;
  logic        cfg_we;
  logic [15:0] cfg_pool_size;

  alloc_scoreboard sb;
  int idle_cycles;
  logic [15:0] pool_now;

  first_fit_region_allocator_core u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_operation(in_operation), .in_request_size(in_request_size),
    .in_release_address(in_release_address),
    .out_valid(out_valid), .out_region_address(out_region_address),
    .out_status(out_status),
    .cfg_we(cfg_we), .cfg_pool_size(cfg_pool_size)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // result checking and stall watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) sb.check_result(out_region_address, out_status);
      if (out_valid || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // drop start for a random gap, then present one item until accepted;
  // start stays high afterwards so a zero gap follows back to back
  task send_item(logic op, logic [15:0] req, logic [15:0] rel);
    int gap;
    gap = $urandom_range(17);
    if ($urandom_range(3) == 0) gap = 0;
    if (gap != 0) begin
      start <= 0;
      repeat (gap) @(posedge clk);
    end
    start <= 1;
    in_operation <= op;
    in_request_size <= req;
    in_release_address <= rel;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_item(op, req, rel);
  endtask

  task wait_drain();
    start <= 0;
    while (sb.pend_addr.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task write_pool(logic [15:0] val);
    wait_drain();
    cfg_we <= 1;
    cfg_pool_size <= val;
    @(posedge clk);
    cfg_we <= 0;
    sb.rebuild(val);
    pool_now = val;
  endtask

  // mostly allocate/free traffic on live regions, some noise
  task random_item();
    int r;
    logic [15:0] sz;
    r = $urandom_range(99);
    if (r < 50) begin
      case ($urandom_range(5))
        0: sz = 16'($urandom);
        1: sz = 16'($urandom_range(3) + 1);
        default: sz = 16'($urandom_range(pool_now / 8 + 1));
      endcase
      send_item(OP_ALLOC, sz, 16'($urandom));
    end else if (r < 90) begin
      send_item(OP_FREE, 16'($urandom), sb.live_base());
    end else begin
      send_item(OP_FREE, 16'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    logic [15:0] pools[5];
    sb = new();
    sb.rebuild(POOL_RESET);
    pool_now = POOL_RESET;
    idle_cycles = 0;
    rst_n = 0;
    start = 0;
    in_operation = OP_ALLOC;
    in_request_size = '0;
    in_release_address = '0;
    cfg_we = 0;
    cfg_pool_size = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: reset pool, zero size, no fit, exact fit, split, merges
    send_item(OP_ALLOC, 16'd0, 16'hFFFF);
    send_item(OP_ALLOC, 16'hFFFF, 16'd0);
    send_item(OP_ALLOC, 16'd100, 16'd0);
    send_item(OP_ALLOC, 16'd200, 16'd0);
    send_item(OP_ALLOC, 16'd300, 16'd0);
    send_item(OP_FREE, 16'hFFFF, 16'd100);
    send_item(OP_FREE, 16'd0, 16'd100);
    send_item(OP_FREE, 16'd0, 16'd0);
    send_item(OP_FREE, 16'd0, 16'd300);
    send_item(OP_ALLOC, 16'd1000, 16'd0);
    send_item(OP_FREE, 16'd0, 16'hFFFF);
    send_item(OP_FREE, 16'd0, 16'd0);
    // table full: sixteen segments from size-1 splits
    write_pool(16'd40);
    for (int k = 0; k < 16; k++) send_item(OP_ALLOC, 16'd1, 16'd0);
    send_item(OP_ALLOC, 16'd24, 16'd0);
    // sender holds off until everything is back
    wait_drain();
    send_item(OP_FREE, 16'd0, 16'd5);
    // zero pool and full-range pool
    write_pool(16'd0);
    send_item(OP_ALLOC, 16'd1, 16'd0);
    write_pool(16'hFFFF);
    send_item(OP_ALLOC, 16'hFFFF, 16'd0);
    send_item(OP_FREE, 16'd0, 16'd0);

    // random phases over several pool sizes
    pools = '{16'd1000, 16'd1, 16'hFFFF, 16'd64, 16'($urandom_range(65535, 1))};
    for (int p = 0; p < 5; p++) begin
      write_pool(pools[p]);
      for (int n = 0; n < 130; n++) random_item();
    end

    wait_drain();
    if (sb.errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule
`default_nettype wire

### first_fit_region_allocator_core.f
rtl/ffra_pkg.sv
rtl/ffra_datapath.sv
rtl/ffra_ctrl.sv
rtl/first_fit_region_allocator_core.sv
test/testbench.sv
